### hdl/cte_pkg.sv
`timescale 1ns / 1ps

package cte_pkg;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_UNSUPPORTED
    } t_status;

    typedef struct packed {
        logic [15:0]        year;
        logic [7:0]         month;
        logic [7:0]         day;
        logic [7:0]         hour;
        logic [7:0]         minute;
        logic [7:0]         second;
        logic [31:0]        nanosecond;
        logic signed [15:0] zone_minutes;
        logic [7:0]         daylight_flags;
    } t_cte_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] epoch_seconds;
    } t_cte_out;

    // classified request handed from front to back
    typedef struct packed {
        t_status     status;
        logic [15:0] days;
        logic [31:0] adj;
    } t_cte_job;

    localparam logic [15:0] YEAR_MIN   = 16'd1900;
    localparam logic [15:0] YEAR_MAX   = 16'd9999;
    localparam logic [15:0] SUP_FIRST  = 16'd1970;
    localparam logic [15:0] SUP_LAST   = 16'd2105;
    localparam logic [31:0] NS_MAX     = 32'd999999999;
    localparam logic signed [15:0] ZONE_LIMIT = 16'sd1440;
    localparam logic signed [15:0] ZONE_NONE  = 16'sd2047;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // 2100 is the only non-leap century year in the supported span
    localparam logic [7:0]  YOFF_2100  = 8'd130;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd29;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### hdl/cte_front.sv
`timescale 1ns / 1ps

module cte_front #(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  cte_pkg::t_cte_in             i_req,
    input  logic [$clog2(DEPTH+1)-1:0]   i_level,
    output logic                         o_push,
    output cte_pkg::t_cte_job            o_job
);
    import cte_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic               accept;
    logic               zone_bad;
    logic               bad_a;
    logic [19:0]        tod_a;
    logic signed [22:0] zone_sec_a;
    logic [28:0]        q_prod;

    logic               r_a_valid;
    logic [15:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic [19:0]        r_tod;
    logic signed [22:0] r_zone_sec;
    logic               r_dst;
    logic               r_bad;
    logic               r_feb29;
    logic [9:0]         r_q;

    logic [16:0] q100;
    logic        leap;
    logic        supported;
    logic [7:0]  yoff;
    logic [5:0]  leaps;
    logic [15:0] days;
    logic [31:0] zone_ext;
    logic [31:0] adj;

    assign o_req_stall = ((CW + 1)'(i_level) + (CW + 1)'(r_a_valid)) >= (CW + 1)'(DEPTH);
    assign accept      = i_req_valid && !o_req_stall;

    // stage A: range checks, time of day, zone in seconds, year / 100
    always_comb begin
        zone_bad = (i_req.zone_minutes != ZONE_NONE) &&
                   ((i_req.zone_minutes < -ZONE_LIMIT) || (i_req.zone_minutes > ZONE_LIMIT));
        bad_a = (i_req.year < YEAR_MIN) || (i_req.year > YEAR_MAX) ||
                (i_req.month == 8'd0) || (i_req.month > 8'd12) ||
                (i_req.day == 8'd0) || (i_req.day > 8'(month_len(i_req.month[3:0]))) ||
                (i_req.hour > 8'd23) || (i_req.minute > 8'd59) || (i_req.second > 8'd59) ||
                (i_req.nanosecond > NS_MAX) || zone_bad ||
                (i_req.daylight_flags[7:2] != 6'd0);
        tod_a = 20'(i_req.hour) * 20'd3600 + 20'(i_req.minute) * 20'd60
              + 20'(i_req.second);
        zone_sec_a = (i_req.zone_minutes == ZONE_NONE) ? 23'sd0
                   : 23'(i_req.zone_minutes) * 23'sd60;
        q_prod = 29'(i_req.year) * 29'(DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
        if (accept) begin
            r_year     <= i_req.year;
            r_month    <= i_req.month[3:0];
            r_day      <= i_req.day[4:0];
            r_tod      <= tod_a;
            r_zone_sec <= zone_sec_a;
            r_dst      <= i_req.daylight_flags[1];
            r_bad      <= bad_a;
            r_feb29    <= (i_req.month == 8'd2) && (i_req.day > 8'd28);
            r_q        <= 10'(q_prod >> DIV100_SHIFT);
        end
    end

    // stage B: leap rule, day count from 1970, UTC adjustment
    always_comb begin
        q100      = 17'(r_q) * 17'd100;
        leap      = (r_year[1:0] == 2'd0) && ((q100 != 17'(r_year)) || (r_q[1:0] == 2'd0));
        supported = (r_year >= SUP_FIRST) && (r_year <= SUP_LAST);
        yoff      = 8'(r_year - SUP_FIRST);
        leaps     = 6'((9'(yoff) + 9'd1) >> 2) - ((yoff > YOFF_2100) ? 6'd1 : 6'd0);
        days      = 16'(yoff) * 16'd365 + 16'(leaps) + 16'(days_before_month(r_month))
                  + ((leap && (r_month > 4'd2)) ? 16'd1 : 16'd0) + 16'(r_day) - 16'd1;
        zone_ext  = 32'(r_zone_sec);
        adj       = 32'(r_tod) - zone_ext - (r_dst ? 32'd3600 : 32'd0);

        o_job.days = days;
        o_job.adj  = adj;
        if (r_bad || (r_feb29 && !leap)) begin
            o_job.status = ST_INVALID;
        end else if (!supported) begin
            o_job.status = ST_UNSUPPORTED;
        end else begin
            o_job.status = ST_OK;
        end
    end

    assign o_push = r_a_valid;

endmodule

### hdl/cte_fifo.sv
`timescale 1ns / 1ps

module cte_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  cte_pkg::t_cte_job            i_push_job,
    input  logic                         i_pop,
    output cte_pkg::t_cte_job            o_head_job,
    output logic                         o_nonempty,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    import cte_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cte_job          r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_level;
    logic              do_pop;

    assign do_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_level <= r_level + CW'(i_push) - CW'(do_pop);
        end
    end

    assign o_head_job = r_mem[r_rd_ptr];
    assign o_nonempty = (r_level != '0);
    assign o_level    = r_level;

endmodule

### hdl/cte_back.sv
`timescale 1ns / 1ps

module cte_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  cte_pkg::t_cte_job   i_job,
    output logic                o_pop,
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output cte_pkg::t_cte_out   o_rsp
);
    import cte_pkg::*;

    logic        r_valid;
    t_cte_out    r_rsp;
    t_cte_out    n_rsp;
    logic [32:0] day_secs;

    assign o_pop = i_job_valid && (!r_valid || !i_rsp_stall);

    always_comb begin
        day_secs      = 33'(i_job.days) * 33'(SECS_PER_DAY);
        n_rsp.status  = i_job.status;
        n_rsp.epoch_seconds = (i_job.status == ST_OK) ? (32'(day_secs) + i_job.adj) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

endmodule

### hdl/calendar_time_validate_to_epoch_core.sv
`timescale 1ns / 1ps
// Calendar time check and conversion to 32-bit Unix seconds.
// Request channel: i_req_valid / o_req_stall carry one broken-down time in
// i_req. Response channel: o_rsp_valid / i_rsp_stall carry status and
// epoch_seconds in o_rsp. A transfer happens on a rising edge with valid high
// and stall low. Every request gives exactly one response, in order.
// Status 0 is success, 1 a field out of range, 2 a year outside 1970..2105;
// epoch_seconds is zero unless status is 0.
// Path: the front-end stage A registers, the queue, then the back-end response register.
// Throughput: one request per cycle while o_req_stall is low; the day-to-seconds multiply in the back
// end and the one-stage front classifier each take one request per cycle.
// The front end stalls only when the queue plus its own stage would exceed
// FIFO_DEPTH entries, so a stalled response fills the queue before
// o_req_stall rises. A held response stays unchanged while i_rsp_stall is
// high. Reset (synchronous, active low) empties the pipeline and the queue;
// no request is lost or duplicated across a stall.
module calendar_time_validate_to_epoch_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  cte_pkg::t_cte_in    i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output cte_pkg::t_cte_out   o_rsp
);
    import cte_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic          push;
    t_cte_job      push_job;
    logic          pop;
    t_cte_job      head_job;
    logic          nonempty;
    logic [CW-1:0] level;

    cte_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .i_level     (level),
        .o_push      (push),
        .o_job       (push_job)
    );

    cte_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head_job (head_job),
        .o_nonempty (nonempty),
        .o_level    (level)
    );

    cte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (nonempty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

### hdl/cte_checker.sv
`timescale 1ns / 1ps

module cte_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                o_req_stall,
    input cte_pkg::t_cte_in    i_req,
    input logic                o_rsp_valid,
    input logic                i_rsp_stall,
    input cte_pkg::t_cte_out   o_rsp
);
    import cte_pkg::*;

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_stall |=> i_req_valid && $stable(i_req))
        else $error("request changed while stalled");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK) |-> o_rsp.epoch_seconds == 32'd0)
        else $error("failed status with nonzero seconds");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == ST_OK) || (o_rsp.status == ST_INVALID) ||
                        (o_rsp.status == ST_UNSUPPORTED))
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind calendar_time_validate_to_epoch_core cte_checker u_cte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);
